>>> rtl/gss_pkg.sv
// Shared types, constants and register indexes for the Gray-Scott stencil pipeline.
package gss_pkg;

    localparam int GRID_WIDTH  = 512;
    localparam int GRID_HEIGHT = 512;
    localparam int COL_W = $clog2(GRID_WIDTH + 1);
    localparam int ROW_W = $clog2(GRID_HEIGHT + 2);
    localparam int ADDR_W = $clog2(GRID_WIDTH);

    localparam int Q_W = 17;
    localparam int CELL_W = 2 * Q_W;
    localparam logic [16:0] Q_ONE = 17'd65536;
    localparam logic [13:0] W_EDGE = 14'd13107;
    localparam logic [11:0] W_DIAG = 12'd3277;

    localparam logic [2:0] REG_FEED = 3'd0;
    localparam logic [2:0] REG_KILL = 3'd1;
    localparam logic [2:0] REG_DIFF_A = 3'd2;
    localparam logic [2:0] REG_DIFF_B = 3'd3;
    localparam logic [2:0] REG_TSTEP = 3'd4;

    typedef logic [Q_W-1:0] q_t;

    typedef struct packed {
        q_t feed;
        q_t kill;
        q_t diff_a;
        q_t diff_b;
        q_t tstep;
    } coef_t;

    // 3x3 neighborhood, already masked outside the grid
    typedef struct packed {
        logic [8:0][CELL_W-1:0] cells;
        logic                   last;
    } win_t;

endpackage

>>> rtl/gss_window.sv
// Line stores, raster counters and 3x3 window; issues one masked neighborhood per cell.
module gss_window (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          advance,
    input  logic          in_valid,
    input  logic [16:0]   cell_a,
    input  logic [16:0]   cell_b,
    input  logic          flush,
    output logic          win_valid,
    output gss_pkg::win_t win
);
    import gss_pkg::*;

    logic [CELL_W-1:0] upper_mem [GRID_WIDTH];
    logic [CELL_W-1:0] middle_mem [GRID_WIDTH];

    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;
    logic [COL_W-1:0] col_next;
    logic [ROW_W-1:0] row_next;

    // stage 1: registered item plus registered line store reads
    logic              s1_valid_reg;
    logic [CELL_W-1:0] s1_cur_reg;
    logic [CELL_W-1:0] s1_up_reg;
    logic [CELL_W-1:0] s1_mid_reg;
    logic [ADDR_W-1:0] s1_col_reg;
    logic [ROW_W-1:0]  s1_row_reg;

    logic [8:0][CELL_W-1:0] win_reg;
    logic [8:0][CELL_W-1:0] win_next;

    logic [ADDR_W-1:0] addr;
    logic [CELL_W-1:0] cur;
    logic              take;
    logic              edge0;
    logic              emit0;
    logic              emitn;
    logic              last0;
    logic [ROW_W-1:0]  rr;
    logic [8:0][CELL_W-1:0] g;
    logic              out_valid_reg;
    win_t              out_reg;

    assign take = in_valid && advance;
    assign addr = col_reg[ADDR_W-1:0];
    assign cur  = flush ? '0 : {cell_b, cell_a};
    assign edge0 = (col_reg == COL_W'(GRID_WIDTH - 1));
    assign last0 = (col_reg == '0) &&
                   (row_reg == ROW_W'(GRID_HEIGHT + 1));

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (take)
        begin
            if (last0)
            begin
                col_next = '0;
                row_next = '0;
            end
            else if (edge0)
            begin
                col_next = '0;
                row_next = (row_reg == ROW_W'(GRID_HEIGHT + 1)) ? '0 : row_reg + 1'b1;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (advance)
                s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            upper_mem[addr] <= middle_mem[addr];
            middle_mem[addr] <= cur;
            s1_up_reg  <= upper_mem[addr];
            s1_mid_reg <= middle_mem[addr];
            s1_cur_reg <= cur;
            s1_col_reg <= addr;
            s1_row_reg <= row_reg;
        end
    end

    // stage 2: shift the window and build the masked neighborhood
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            win_next[i*3+0] = win_reg[i*3+1];
            win_next[i*3+1] = win_reg[i*3+2];
        end
        win_next[2] = s1_up_reg;
        win_next[5] = s1_mid_reg;
        win_next[8] = s1_cur_reg;

        emit0 = (s1_col_reg == '0) && (s1_row_reg >= ROW_W'(2)) &&
                (s1_row_reg <= ROW_W'(GRID_HEIGHT + 1));
        emitn = (s1_col_reg != '0) && (s1_row_reg >= ROW_W'(1)) &&
                (s1_row_reg <= ROW_W'(GRID_HEIGHT));

        g = win_next;
        rr = s1_row_reg - 1'b1;
        if (s1_col_reg == '0)
        begin
            for (int i = 0; i < 3; i++)
            begin
                g[i*3+0] = win_reg[i*3+1];
                g[i*3+1] = win_reg[i*3+2];
                g[i*3+2] = '0;
            end
            rr = s1_row_reg - ROW_W'(2);
        end
        else if (s1_col_reg == ADDR_W'(1))
        begin
            g[0] = '0;
            g[3] = '0;
            g[6] = '0;
        end
        if (rr == '0)
        begin
            g[0] = '0;
            g[1] = '0;
            g[2] = '0;
        end
        if (rr == ROW_W'(GRID_HEIGHT - 1))
        begin
            g[6] = '0;
            g[7] = '0;
            g[8] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= s1_valid_reg && (emit0 || emitn);
            if (s1_valid_reg)
                win_reg <= win_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && s1_valid_reg)
        begin
            out_reg.cells <= g;
            out_reg.last  <= emit0 && (s1_row_reg == ROW_W'(GRID_HEIGHT + 1));
        end
    end

    assign win_valid = out_valid_reg;
    assign win = out_reg;

    a_ctr_range: assert property (@(posedge clk) disable iff (!rst_n)
        col_reg < COL_W'(GRID_WIDTH) && row_reg <= ROW_W'(GRID_HEIGHT + 1))
        else $error("raster counter out of range");
    a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        take && last0 |=> col_reg == '0 && row_reg == '0)
        else $error("frame wrap missed");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(col_reg) && $stable(row_reg))
        else $error("counters moved during stall");

endmodule

>>> rtl/gss_update.sv
// Arithmetic pipeline: Laplacian, reaction, deltas and saturated Euler update.
module gss_update (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           advance,
    input  gss_pkg::coef_t coef,
    input  logic           win_valid,
    input  gss_pkg::win_t  win,
    output logic           res_valid,
    output logic [16:0]    res_a,
    output logic [16:0]    res_b,
    output logic           res_last
);
    import gss_pkg::*;

    // stage A: neighbor sums, a*b
    logic        va_reg;
    logic [19:0] ea_reg, eb_reg, da_reg, db_reg;
    q_t          a_a_reg, b_a_reg;
    logic [33:0] ab_reg;
    logic        l_a_reg;

    // stage B: weighted sums, reaction part 2
    logic        vb_reg;
    logic [35:0] wa_reg, wb_reg;
    q_t          a_b_reg, b_b_reg;
    logic [34:0] ab2_reg;
    logic        l_b_reg;

    // stage C: laplacians, reaction
    logic               vc_reg;
    logic signed [21:0] lapa_reg, lapb_reg;
    logic [35:0]        react_reg;
    q_t                 a_c_reg, b_c_reg;
    logic               l_c_reg;

    // stage D: coefficient products
    logic               vd_reg;
    logic signed [40:0] pda_reg, pdb_reg, pf_reg, pk_reg;
    logic [35:0]        react_d_reg;
    q_t                 a_d_reg, b_d_reg;
    logic               l_d_reg;

    // stage E: deltas
    logic               ve_reg;
    logic signed [23:0] dela_reg, delb_reg;
    q_t                 a_e_reg, b_e_reg;
    logic               l_e_reg;

    // stage F: time step products
    logic               vf_reg;
    logic signed [41:0] ta_reg, tb_reg;
    q_t                 a_f_reg, b_f_reg;
    logic               l_f_reg;

    // output register
    logic        vo_reg;
    q_t          oa_reg, ob_reg;
    logic        lo_reg;

    function automatic logic signed [62:0] qdiv(input logic signed [62:0] x);
        // truncating divide by 65536 toward zero
        logic signed [62:0] adj;
        adj = (x < 0) ? x + 63'sd65535 : x;
        return adj >>> 16;
    endfunction

    function automatic q_t sat(input logic signed [63:0] v);
        if (v < 0)
            return '0;
        else if (v > 64'sd65536)
            return Q_ONE;
        else
            return v[16:0];
    endfunction

    logic signed [62:0] lap_a_w, lap_b_w;
    logic signed [62:0] d_a_w, d_b_w;

    always_comb
    begin
        lap_a_w = qdiv(63'(signed'({1'b0, wa_reg}))) - 63'(signed'({1'b0, a_b_reg}));
        lap_b_w = qdiv(63'(signed'({1'b0, wb_reg}))) - 63'(signed'({1'b0, b_b_reg}));
        d_a_w = qdiv(63'(pda_reg)) - 63'(signed'({1'b0, react_d_reg})) + qdiv(63'(pf_reg));
        d_b_w = qdiv(63'(pdb_reg)) + 63'(signed'({1'b0, react_d_reg})) - qdiv(63'(pk_reg));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
            ve_reg <= 1'b0;
            vf_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else if (advance)
        begin
            va_reg <= win_valid;
            vb_reg <= va_reg;
            vc_reg <= vb_reg;
            vd_reg <= vc_reg;
            ve_reg <= vd_reg;
            vf_reg <= ve_reg;
            vo_reg <= vf_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            ea_reg <= 20'(win.cells[1][16:0]) + 20'(win.cells[3][16:0])
                    + 20'(win.cells[5][16:0]) + 20'(win.cells[7][16:0]);
            eb_reg <= 20'(win.cells[1][33:17]) + 20'(win.cells[3][33:17])
                    + 20'(win.cells[5][33:17]) + 20'(win.cells[7][33:17]);
            da_reg <= 20'(win.cells[0][16:0]) + 20'(win.cells[2][16:0])
                    + 20'(win.cells[6][16:0]) + 20'(win.cells[8][16:0]);
            db_reg <= 20'(win.cells[0][33:17]) + 20'(win.cells[2][33:17])
                    + 20'(win.cells[6][33:17]) + 20'(win.cells[8][33:17]);
            a_a_reg <= win.cells[4][16:0];
            b_a_reg <= win.cells[4][33:17];
            ab_reg  <= win.cells[4][16:0] * win.cells[4][33:17];
            l_a_reg <= win.last;

            wa_reg  <= 36'(ea_reg) * 36'(W_EDGE) + 36'(da_reg) * 36'(W_DIAG);
            wb_reg  <= 36'(eb_reg) * 36'(W_EDGE) + 36'(db_reg) * 36'(W_DIAG);
            ab2_reg <= 35'(ab_reg[33:16]) * 35'(b_a_reg);
            a_b_reg <= a_a_reg;
            b_b_reg <= b_a_reg;
            l_b_reg <= l_a_reg;

            lapa_reg  <= lap_a_w[21:0];
            lapb_reg  <= lap_b_w[21:0];
            react_reg <= 36'(ab2_reg[34:16]);
            a_c_reg <= a_b_reg;
            b_c_reg <= b_b_reg;
            l_c_reg <= l_b_reg;

            pda_reg <= signed'({1'b0, coef.diff_a}) * lapa_reg;
            pdb_reg <= signed'({1'b0, coef.diff_b}) * lapb_reg;
            pf_reg  <= signed'({1'b0, coef.feed})
                     * (22'sd65536 - signed'(22'({1'b0, a_c_reg})));
            pk_reg  <= 41'({1'b0, coef.kill} + {1'b0, coef.feed}) * 41'(b_c_reg);
            react_d_reg <= react_reg;
            a_d_reg <= a_c_reg;
            b_d_reg <= b_c_reg;
            l_d_reg <= l_c_reg;

            dela_reg <= d_a_w[23:0];
            delb_reg <= d_b_w[23:0];
            a_e_reg <= a_d_reg;
            b_e_reg <= b_d_reg;
            l_e_reg <= l_d_reg;

            ta_reg <= signed'({1'b0, coef.tstep}) * dela_reg;
            tb_reg <= signed'({1'b0, coef.tstep}) * delb_reg;
            a_f_reg <= a_e_reg;
            b_f_reg <= b_e_reg;
            l_f_reg <= l_e_reg;

            oa_reg <= sat(64'(qdiv(63'(ta_reg))) + 64'(a_f_reg));
            ob_reg <= sat(64'(qdiv(63'(tb_reg))) + 64'(b_f_reg));
            lo_reg <= l_f_reg;
        end
    end

    assign res_valid = vo_reg;
    assign res_a = oa_reg;
    assign res_b = ob_reg;
    assign res_last = lo_reg;

    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        vo_reg |-> oa_reg <= Q_ONE && ob_reg <= Q_ONE)
        else $error("result above saturation bound");
    a_flow: assert property (@(posedge clk) disable iff (!rst_n)
        advance && vf_reg |=> vo_reg)
        else $error("valid lost in pipeline");

endmodule

>>> rtl/gray_scott_stencil_step.sv
// Top level: config registers, window stage and arithmetic pipeline of the Gray-Scott step.
//   channel  | handshake        | payload
//   in       | in_valid/in_stall | cell_a, cell_b, flush
//   out      | out_valid/out_stall | new_a, new_b, last_of_frame
//   cfg      | cfg_we           | cfg_index, cfg_data
// One cell per cycle unless a held result stalls the pipeline.
// The whole pipeline advances together; out_stall on a valid result freezes every stage.
// in_stall follows out_stall while the output register holds a result.
// Reset clears counters, window and valid bits; line stores hold junk until written.
module gray_scott_stencil_step (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [16:0] cell_a,
    input  logic [16:0] cell_b,
    input  logic        flush,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [16:0] new_a,
    output logic [16:0] new_b,
    output logic        last_of_frame,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);
    import gss_pkg::*;

    coef_t coef_reg;
    logic  advance;
    logic  win_valid;
    win_t  win;

    assign advance  = !(out_valid && out_stall);
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg.feed   <= 17'd3572;
            coef_reg.kill   <= 17'd4063;
            coef_reg.diff_a <= 17'd65536;
            coef_reg.diff_b <= 17'd32768;
            coef_reg.tstep  <= 17'd65536;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_FEED:   coef_reg.feed   <= cfg_data;
                REG_KILL:   coef_reg.kill   <= cfg_data;
                REG_DIFF_A: coef_reg.diff_a <= cfg_data;
                REG_DIFF_B: coef_reg.diff_b <= cfg_data;
                REG_TSTEP:  coef_reg.tstep  <= cfg_data;
                default:    ;
            endcase
        end
    end

    gss_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .in_valid  (in_valid),
        .cell_a    (cell_a),
        .cell_b    (cell_b),
        .flush     (flush),
        .win_valid (win_valid),
        .win       (win)
    );

    gss_update u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .coef      (coef_reg),
        .win_valid (win_valid),
        .win       (win),
        .res_valid (out_valid),
        .res_a     (new_a),
        .res_b     (new_b),
        .res_last  (last_of_frame)
    );

    a_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(new_a) && $stable(new_b))
        else $error("stalled result changed");
    a_install: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid && out_stall)
        else $error("input stalled without cause");

endmodule
